// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define CDRF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define CDRF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ----- rtl/core/cdrf_pkg.sv -----
// ----------------------------------------------------------------------------
// cdrf_pkg
// Shared types and constants of the cumulative density rank filter.
// ----------------------------------------------------------------------------
package cdrf_pkg;

  localparam int PROB_W     = 16;
  localparam int TGT_W      = 6;
  localparam int DENS_W     = 17;
  localparam int IN_DATA_W  = 24;   // prob + target_index, padded to bytes
  localparam int OUT_DATA_W = 8;    // pass, padded to a byte
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DENS_W-1:0] DENS_RESET = 17'd65536;

  // Register index, taken from paddr[2] (registers are 4 bytes apart).
  localparam logic REG_MIN_DENSITY = 1'b0;

  typedef enum logic [2:0] {
    ST_LOAD,    // storing entries
    ST_RDT,     // read target entry
    ST_LDT,     // latch target probability
    ST_SCAN,    // walk the stored set
    ST_DRAIN,   // last accumulate
    ST_MUL,     // total * min_density
    ST_CMP,     // final compare
    ST_OUT      // hand result to output register
  } cdrf_state_t;

  typedef struct packed {
    logic load;      // store one entry
    logic load_last; // entry closes the set
    logic rd_tgt;    // address memory with the target index
    logic ld_tgt;    // capture target probability, restart scan
    logic scan;      // issue one scan read
    logic mul;       // register the product
    logic cmp;       // register the decision
    logic emit;      // result goes out, set is cleared
  } cdrf_cmd_t;

  typedef struct packed {
    logic scan_last; // current scan read is the last entry
  } cdrf_sts_t;

endpackage

// ----- rtl/core/cdrf_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdrf_ctrl
// Sequencer: loading, target fetch, scan and decision steps.
// ----------------------------------------------------------------------------
module cdrf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  input  logic              out_busy,
  input  cdrf_pkg::cdrf_sts_t sts,
  output cdrf_pkg::cdrf_cmd_t cmd
);
  import cdrf_pkg::*;

  cdrf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_tready     = 1'b1;
        cmd.load      = in_tvalid;
        cmd.load_last = in_tvalid && in_tlast;
        if (in_tvalid && in_tlast) begin
          state_nxt = ST_RDT;
        end
      end
      ST_RDT: begin
        cmd.rd_tgt = 1'b1;
        state_nxt  = ST_LDT;
      end
      ST_LDT: begin
        cmd.ld_tgt = 1'b1;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

// ----- rtl/core/cdrf_dp.sv -----
// ----------------------------------------------------------------------------
// cdrf_dp
// Datapath: probability store, running total, rank scan and threshold test.
// ----------------------------------------------------------------------------
module cdrf_dp #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cdrf_pkg::cdrf_cmd_t           cmd,
  output cdrf_pkg::cdrf_sts_t           sts,
  input  logic [cdrf_pkg::PROB_W-1:0]   prob,
  input  logic [cdrf_pkg::TGT_W-1:0]    target_index,
  input  logic [cdrf_pkg::DENS_W-1:0]   min_density,
  output logic                          pass
);
  import cdrf_pkg::*;

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W  = PROB_W + $clog2(MAX_ENTRIES);
  localparam int CMPW   = (CNT_W > TGT_W) ? CNT_W : TGT_W;
  localparam int PROD_W = SUM_W + DENS_W;

  logic [PROB_W-1:0] mem [MAX_ENTRIES];

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SUM_W-1:0]  total_r, total_nxt;
  logic [TGT_W-1:0]  target_r;
  logic [PROB_W-1:0] rd_data_r;
  logic [PROB_W-1:0] tp_r;
  logic [IDX_W-1:0]  scan_idx_r;
  logic [IDX_W-1:0]  acc_idx_r;
  logic              acc_vld_r;
  logic [SUM_W-1:0]  ahead_r, ahead_nxt;
  logic [PROD_W-1:0] prod_r;
  logic              pass_r;

  logic [IDX_W-1:0]  rd_addr;
  logic              store_en;
  logic              acc_hit;
  logic              tgt_ok;
  logic [PROD_W-1:0] lhs;

  assign store_en = cmd.load && (count_r < CNT_W'(MAX_ENTRIES));
  assign rd_addr  = cmd.rd_tgt ? IDX_W'(target_r) : scan_idx_r;

  // memory: one write port (load), one registered read port (target / scan)
  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[count_r[IDX_W-1:0]] <= prob;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt = count_r;
    total_nxt = total_r;
    if (cmd.emit) begin
      count_nxt = '0;
      total_nxt = '0;
    end else if (store_en) begin
      count_nxt = count_r + CNT_W'(1);
      total_nxt = total_r + SUM_W'(prob);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
    end else begin
      count_r <= count_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_last) begin
      target_r <= target_index;
    end
  end

  // rank scan: entry ahead if larger, or equal with a higher index
  assign acc_hit = acc_vld_r &&
                   ((rd_data_r > tp_r) ||
                    ((rd_data_r == tp_r) && (CMPW'(acc_idx_r) > CMPW'(target_r))));

  always_comb begin
    ahead_nxt = ahead_r;
    if (cmd.ld_tgt) begin
      ahead_nxt = '0;
    end else if (acc_hit) begin
      ahead_nxt = ahead_r + SUM_W'(rd_data_r);
    end
  end

  assign sts.scan_last = (CNT_W'(scan_idx_r) + CNT_W'(1)) == count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= 1'b0;
    end else begin
      acc_vld_r <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    ahead_r   <= ahead_nxt;
    acc_idx_r <= scan_idx_r;
    if (cmd.ld_tgt) begin
      tp_r       <= rd_data_r;
      scan_idx_r <= '0;
    end else if (cmd.scan) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end
  end

  // threshold: target in set and nonzero, and ahead * 2^16 <= total * min_density
  assign tgt_ok = CMPW'(target_r) < CMPW'(count_r);
  assign lhs    = PROD_W'({ahead_r, 16'h0000});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(total_r) * PROD_W'(min_density);
    end
    if (cmd.cmp) begin
      pass_r <= tgt_ok && (tp_r != '0) && (lhs <= prod_r);
    end
  end

  assign pass = pass_r;

endmodule

// ----- rtl/core/cumulative_density_rank_filter.sv -----
// ----------------------------------------------------------------------------
// cumulative_density_rank_filter
// Top-p style rank filter: loads a probability set and tests one entry.
// ----------------------------------------------------------------------------
// Entries stream in one per cycle on the in_ channel; tlast closes the set
// and the target index of that closing transaction is the one tested. After
// the closing transaction the input stalls while the block reads the target
// entry and then walks the stored set once through the single read port of
// the probability memory, one entry per cycle, and then takes the decision;
// it stays stalled until the result passes to the output register, which
// waits for any previous result to be taken on out_tready. The next set
// loads while a result still waits on out_tready; its own result then waits
// for that one to be taken.
// The result is one transaction per set with pass in out_tdata[0].
// Entries beyond MAX_ENTRIES are dropped, but a dropped tlast still closes
// the set. min_density (Q16, reset 1.0) sits at byte address 0 of the APB
// port and must only be written while the block is idle. The memory needs
// no clearing pass: only entries of the current set are read.
module cumulative_density_rank_filter #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: [15:0] prob, [21:16] target_index, [23:22] zero
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cdrf_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,
  // out_tdata: [0] pass, [7:1] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cdrf_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [cdrf_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [cdrf_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [cdrf_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import cdrf_pkg::*;

  cdrf_cmd_t         cmd;
  cdrf_sts_t         sts;
  logic              pass;
  logic              out_busy;
  logic [DENS_W-1:0] min_density_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_pass_r;
  logic              cfg_wr;

  // ---- configuration register ----
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_MIN_DENSITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_density_r <= DENS_RESET;
    end else if (cfg_wr) begin
      min_density_r <= cfg_pwdata[DENS_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_MIN_DENSITY) ?
                      CFG_DATA_W'(min_density_r) : '0;

  // ---- output register: holds the result until the transaction completes ----
  assign out_busy = out_valid_r && !out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pass_r <= pass;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_pass_r);

  cdrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .out_busy  (out_busy),
    .sts       (sts),
    .cmd       (cmd)
  );

  cdrf_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .prob         (in_tdata[PROB_W-1:0]),
    .target_index (in_tdata[PROB_W+TGT_W-1:PROB_W]),
    .min_density  (min_density_r),
    .pass         (pass)
  );

endmodule

// ----- rtl/core/cdrf_chk.sv -----
// ----------------------------------------------------------------------------
// cdrf_chk
// Port-level checker for the cumulative density rank filter, bound to top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdrf_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // a pending result holds until taken
  `CDRF_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // closing transaction starts evaluation: input stalls next cycle
  `CDRF_ASSERT(a_eval_stall, clk, rst_n, in_tvalid && in_tready && in_tlast |=> !in_tready)

  // a result only follows an evaluation, during which the input was stalled
  `CDRF_ASSERT(a_out_after_last, clk, rst_n, $rose(out_tvalid) |-> $past(!in_tready))

  // padding bits of the result stay zero
  `CDRF_ASSERT(a_out_pad, clk, rst_n, out_tvalid |-> out_tdata[7:1] == 7'd0)

  // reset leaves no result pending
  `CDRF_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_tvalid)

endmodule

bind cumulative_density_rank_filter cdrf_chk u_cdrf_chk (.*);

// ----- dv/cumulative_density_rank_filter_tb.sv -----
// ----------------------------------------------------------------------------
// cumulative_density_rank_filter_tb
// Self-checking bench for the cumulative density rank filter.
// ----------------------------------------------------------------------------
// Streams probability sets into in_ and checks one pass/fail verdict per
// closed set on out_. A shadow rank model in the bench mirrors the store, the
// running mass and min_density, and works out each verdict when the closing
// transaction is accepted. Directed sets cover ties, a zero target, an
// out-of-set target, and density at zero and above one. They are followed by
// random phases that sweep min_density and the idle and stall patterns,
// including full and overflowing sets.
// ----------------------------------------------------------------------------
module cumulative_density_rank_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdrf_pkg::*;

  localparam int MAX_ENTRIES = 64;
  localparam logic [CFG_ADDR_W-1:0] DENSITY_ADDR = {REG_MIN_DENSITY, 2'b00};

  // One probability entry as it travels on in_.
  typedef struct {
    logic [PROB_W-1:0] prob;
    logic [TGT_W-1:0]  tgt;
    logic              last;
  } entry_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  in_tlast    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Entries waiting to go out, and verdicts waiting to come back.
  entry_t entry_q[$];
  bit     verdict_q[$];

  // Shadow of the block: stored set, entry count, running mass, density.
  logic [PROB_W-1:0] shadow_prob [MAX_ENTRIES];
  int unsigned       shadow_count   = 0;
  longint unsigned   shadow_total   = 0;
  longint unsigned   shadow_density = 65536;

  int  mismatch_count = 0;
  int  send_idle_pct  = 0;
  int  rx_stall_pct   = 0;
  bit  in_took        = 1'b0;
  bit  hold_go        = 1'b0;
  bit  rx_hold        = 1'b0;

  cumulative_density_rank_filter #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),      // [15:0] prob, [21:16] target_index, [23:22] zero
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),     // [0] pass, [7:1] zero
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Shadow rank model
  // --------------------------------------------------------------------------

  // Mass ranked ahead of the target must not exceed total * density / 2^16.
  // Ties rank the higher index first. A zero or out-of-set target fails.
  function automatic bit target_passes(input logic [TGT_W-1:0] tgt);
    longint unsigned   ahead;
    logic [PROB_W-1:0] tp;
    ahead = 0;
    if (tgt >= shadow_count) return 1'b0;
    tp = shadow_prob[tgt];
    if (tp == 0) return 1'b0;
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_prob[i] > tp || (shadow_prob[i] == tp && i > tgt))
        ahead += shadow_prob[i];
    end
    return (ahead << 16) <= shadow_total * shadow_density;
  endfunction

  // Entries past MAX_ENTRIES are dropped, yet a dropped last still closes.
  task automatic absorb_entry(input entry_t e);
    if (shadow_count < MAX_ENTRIES) begin
      shadow_prob[shadow_count] = e.prob;
      shadow_count++;
      shadow_total += e.prob;
    end
    if (e.last) begin
      verdict_q = {verdict_q, target_passes(e.tgt)};
      shadow_count = 0;
      shadow_total = 0;
    end
  endtask

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // --------------------------------------------------------------------------
  // in_ driver: valid holds until the transaction is taken; gaps between
  // transactions follow send_idle_pct.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_took = 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      absorb_entry(entry_q.pop_front());
      in_took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_took)) begin
      if (entry_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, entry_q[0].tgt, entry_q[0].prob};
        in_tlast  <= entry_q[0].last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // out_ side: random backpressure, plus one long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n || rx_hold)
      out_tready <= 1'b0;
    else
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Long stall so finished sets pile up and the block backs up into in_.
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk);
    rx_hold = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0)
        flag_mismatch("unexpected result, pass", -1, out_tdata[0]);
      else if (out_tdata[0] !== verdict_q.pop_front())
        flag_mismatch("pass", !out_tdata[0], out_tdata[0]);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_entry(input int prob, input int tgt, input bit last);
    entry_t e;
    e.prob = prob[PROB_W-1:0];
    e.tgt  = tgt[TGT_W-1:0];
    e.last = last;
    entry_q = {entry_q, e};
  endtask

  // One set of n entries; the value mix varies so ties and zeros show up.
  task automatic queue_random_set(input int n);
    int flavor;
    int tgt;
    int top;
    int p;
    flavor = $urandom_range(3);
    top    = (n > MAX_ENTRIES ? MAX_ENTRIES : n) - 1;
    tgt    = ($urandom_range(9) < 8) ? $urandom_range(top) : $urandom_range(63);
    for (int i = 0; i < n; i++) begin
      case (flavor)
        0: begin
          p = $urandom_range(65535);
        end
        1: begin
          p = $urandom_range(3);
        end
        2: begin
          case ($urandom_range(4))
            0: p = 0;
            1: p = 1;
            2: p = 65535;
            3: p = 32768;
            default: p = $urandom_range(65535);
          endcase
        end
        default: begin
          p = ($urandom_range(3) == 0) ? 0 : $urandom_range(65535);
        end
      endcase
      queue_entry(p, tgt, i == n - 1);
    end
  endtask

  task automatic wait_drained;
    @(posedge clk);
    while (entry_q.size() != 0 || verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= DENSITY_ADDR;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Only touched with the block idle: drained, then past the scan latency.
  task automatic program_density(input logic [DENS_W-1:0] value);
    logic [CFG_DATA_W-1:0] rd;
    wait_drained();
    repeat (80) @(posedge clk);
    apb_access(1'b1, CFG_DATA_W'(value), rd);
    shadow_density = value;
    apb_access(1'b0, '0, rd);
    if (rd !== CFG_DATA_W'(value))
      flag_mismatch("min_density readback", value, rd);
  endtask

  initial begin
    int idle_mode;
    int phase_items;
    int n;
    logic [DENS_W-1:0] densities [10];

    densities = '{17'd32768, 17'd131071, 17'd0, 17'd65535, 17'd1,
                  17'd65536, 17'd98304, 17'd16384, 17'd0, 17'd0};
    densities[8] = 17'($urandom_range(65536));
    densities[9] = 17'($urandom_range(131071));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset density (1.0): single full entry passes, zero target
    // fails, target past the set fails, all-ones target index
    queue_entry(65535, 0, 1'b1);
    queue_entry(0, 0, 1'b1);
    queue_entry(1, 5, 1'b0);
    queue_entry(2, 5, 1'b1);
    queue_entry(65535, 63, 1'b1);

    // Density zero: only the top-ranked entry survives; equal values rank
    // the higher index first
    program_density(17'd0);
    queue_entry(7, 2, 1'b0);
    queue_entry(7, 2, 1'b0);
    queue_entry(7, 2, 1'b1);
    queue_entry(7, 0, 1'b0);
    queue_entry(7, 0, 1'b0);
    queue_entry(7, 0, 1'b1);
    queue_entry(0, 1, 1'b0);
    queue_entry(9, 1, 1'b1);

    // Density above one behaves like 1.0
    program_density(17'd131071);
    queue_entry(1, 0, 1'b0);
    queue_entry(65535, 0, 1'b0);
    queue_entry(3, 0, 1'b1);

    // Random phases, each with its own density and idle pattern
    for (int ph = 0; ph < 10; ph++) begin
      program_density(densities[ph]);
      idle_mode = ph % 4;
      send_idle_pct = (idle_mode == 1) ? 49 : (idle_mode == 3) ? 32 : 0;
      rx_stall_pct  = (idle_mode == 2) ? 49 : (idle_mode == 3) ? 32 : 0;
      phase_items = 0;
      if (ph == 3) begin
        queue_random_set(MAX_ENTRIES);        // exactly full
        phase_items += MAX_ENTRIES;
      end
      if (ph == 5 || ph == 8) begin
        n = MAX_ENTRIES + $urandom_range(1, 6);  // overflow, last dropped
        queue_random_set(n);
        phase_items += n;
      end
      while (phase_items < 190) begin
        n = ($urandom_range(19) == 0) ? $urandom_range(17, 63) : $urandom_range(1, 16);
        queue_random_set(n);
        phase_items += n;
      end
      if (ph == 0) hold_go = 1'b1;
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
